// File: hw/rtl/fqd_pkg.sv
// shared constants and helpers for the fifo queue with delete-by-value
// no dependencies; used by fifo_queue_with_delete

package fqd_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // fixed widths of the channel fields
    localparam int OP_W        = 2;
    localparam int ITEM_W      = 32;
    localparam int COUNT_OUT_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
    localparam logic [OP_W-1:0] OP_LENGTH  = 2'd3;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // physical slot of a logical offset from the head (off never exceeds the depth)
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] head,
        input logic [CNT_W-1:0]  off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/fqd_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// no dependencies; used by fifo_queue_with_delete

module fqd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/fifo_queue_with_delete.sv
// fifo queue with delete-by-value, one item in work at a time; depends on fqd_pkg and fqd_ram
// enqueue, length query and immediate rejects go through the reply state to the output
// register; dequeue reads the head entry first; delete makes one ram read a cycle, since
// the scan up to the match and the moves of later entries together visit each stored
// entry once; the next item is taken only once the result is in the output register
// reset clears head, count, state and output valid; ram contents are not cleared

module fifo_queue_with_delete (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fqd_pkg::OP_W-1:0]        operation,
    input  logic [fqd_pkg::ITEM_W-1:0]      item_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic [fqd_pkg::ITEM_W-1:0]      value_out,
    output logic [fqd_pkg::COUNT_OUT_W-1:0] entry_count
);

    localparam int ADDR_W = fqd_pkg::ADDR_W;
    localparam int CNT_W  = fqd_pkg::CNT_W;
    localparam int VAL_W  = fqd_pkg::VALUE_WIDTH;

    // state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEQ    = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_REPLY  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              res_status_reg, res_status_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;

    logic                   out_valid_reg;
    logic                   status_reg;
    logic [VAL_W-1:0]       value_out_reg;
    logic [CNT_W-1:0]       entry_count_reg;

    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [VAL_W-1:0]       ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [VAL_W-1:0]       ram_rd_data;

    logic                   out_free;
    logic                   out_load;
    logic [VAL_W-1:0]       in_v;
    logic [CNT_W-1:0]       count_m1;

    // entry storage
    fqd_ram #(
        .DEPTH (fqd_pkg::QUEUE_DEPTH),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign in_v     = VAL_W'(item_value);
    assign count_m1 = count_reg - CNT_W'(1);

    // sequencer: read, compare, move and write back through the ram
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        wr_idx_next     = wr_idx_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = fqd_pkg::slot_of(head_reg, count_reg);
        ram_wr_data     = in_v;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = head_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = fqd_pkg::STATUS_OK;
                    res_value_next  = '0;
                    state_next      = S_REPLY;
                    case (operation)
                        fqd_pkg::OP_ENQUEUE:
                        begin
                            if (in_v == '0 || count_reg == CNT_W'(fqd_pkg::QUEUE_DEPTH))
                            begin
                                res_status_next = fqd_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        fqd_pkg::OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = fqd_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = S_DEQ;
                            end
                        end
                        fqd_pkg::OP_DELETE:
                        begin
                            if (in_v == '0 || count_reg == '0)
                            begin
                                res_status_next = fqd_pkg::STATUS_ERR;
                            end
                            else
                            begin
                                value_next     = in_v;
                                rd_idx_next    = '0;
                                cmp_valid_next = 1'b0;
                                state_next     = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            // length query: nothing changes
                        end
                    endcase
                end
            end

            S_DEQ:
            begin
                // head entry arrives from the ram
                res_value_next = ram_rd_data;
                count_next     = count_m1;
                head_next      = (count_m1 == '0) ? '0 : fqd_pkg::slot_of(head_reg, CNT_W'(1));
                state_next     = S_REPLY;
            end

            S_SEARCH:
            begin
                // reads run one ahead of the compare
                ram_rd_addr = fqd_pkg::slot_of(head_reg, rd_idx_reg);
                if (cmp_valid_reg && ram_rd_data == value_reg)
                begin
                    cmp_valid_next = 1'b0;
                    if (CNT_W'(cmp_idx_reg) == count_m1)
                    begin
                        // hit on the last entry: nothing to move
                        count_next      = count_m1;
                        head_next       = (count_m1 == '0) ? '0 : head_reg;
                        res_status_next = fqd_pkg::STATUS_OK;
                        state_next      = S_REPLY;
                    end
                    else
                    begin
                        // the read of the entry after the hit goes out now
                        ram_rd_en   = 1'b1;
                        wr_idx_next = cmp_idx_reg;
                        state_next  = S_SHIFT;
                    end
                end
                else if (cmp_valid_reg && CNT_W'(cmp_idx_reg) == count_m1)
                begin
                    // scanned all entries without a match
                    cmp_valid_next  = 1'b0;
                    res_status_next = fqd_pkg::STATUS_ERR;
                    state_next      = S_REPLY;
                end
                else
                begin
                    ram_rd_en      = (rd_idx_reg < count_reg);
                    cmp_valid_next = ram_rd_en;
                    cmp_idx_next   = rd_idx_reg[ADDR_W-1:0];
                    if (ram_rd_en)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                // move the next entry one place toward the head
                ram_wr_en   = 1'b1;
                ram_wr_addr = fqd_pkg::slot_of(head_reg, CNT_W'(wr_idx_reg));
                ram_wr_data = ram_rd_data;
                if ((CNT_W+1)'(wr_idx_reg) + (CNT_W+1)'(2) < (CNT_W+1)'(count_reg))
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = fqd_pkg::slot_of(head_reg, CNT_W'(wr_idx_reg) + CNT_W'(2));
                    wr_idx_next = wr_idx_reg + ADDR_W'(1);
                end
                else
                begin
                    count_next      = count_m1;
                    head_next       = (count_m1 == '0) ? '0 : head_reg;
                    res_status_next = fqd_pkg::STATUS_OK;
                    state_next      = S_REPLY;
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        wr_idx_reg     <= wr_idx_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            value_out_reg   <= res_value_reg;
            entry_count_reg <= count_reg;
        end
    end

    // output transfer
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = fqd_pkg::ITEM_W'(value_out_reg);
    assign entry_count = fqd_pkg::COUNT_OUT_W'(entry_count_reg);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the fifo queue with delete-by-value
// depends on fqd_pkg and fifo_queue_with_delete; predicts every response in a scoreboard class

module tb_top;

    // one predicted response
    typedef struct {
        logic                            status;
        logic [fqd_pkg::ITEM_W-1:0]      value;
        logic [fqd_pkg::COUNT_OUT_W-1:0] count;
    } queue_result_t;

    // queue predictor and response checker
    class queue_scoreboard;
        logic [fqd_pkg::ITEM_W-1:0] store [fqd_pkg::QUEUE_DEPTH];
        int                head;
        int                fill;
        queue_result_t     expected_responses[$];
        int                failures;
        int                n_responses;
        int                n_ops [4];
        int                n_full;
        int                n_full_rejects;
        int                n_delete_hits;

        function new();
            head = 0;
            fill = 0;
            failures = 0;
            n_responses = 0;
            n_full = 0;
            n_full_rejects = 0;
            n_delete_hits = 0;
            foreach (n_ops[i])
            begin
                n_ops[i] = 0;
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // apply one accepted request to the predicted queue
        function void record_request(logic [fqd_pkg::OP_W-1:0] op,
                                     logic [fqd_pkg::ITEM_W-1:0] val);
            queue_result_t want;
            int            hit;
            int            i;
            bit            found;
            want.status = fqd_pkg::STATUS_ERR;
            want.value  = '0;
            n_ops[op]++;
            case (op)
                fqd_pkg::OP_ENQUEUE:
                begin
                    if (val != '0 && fill < fqd_pkg::QUEUE_DEPTH)
                    begin
                        store[(head + fill) % fqd_pkg::QUEUE_DEPTH] = val;
                        fill++;
                        want.status = fqd_pkg::STATUS_OK;
                        if (fill == fqd_pkg::QUEUE_DEPTH)
                        begin
                            n_full++;
                        end
                    end
                    else if (val != '0)
                    begin
                        n_full_rejects++;
                    end
                end
                fqd_pkg::OP_DEQUEUE:
                begin
                    if (fill > 0)
                    begin
                        want.value  = store[head];
                        want.status = fqd_pkg::STATUS_OK;
                        head = (head + 1) % fqd_pkg::QUEUE_DEPTH;
                        fill--;
                        if (fill == 0)
                        begin
                            head = 0;
                        end
                    end
                end
                fqd_pkg::OP_DELETE:
                begin
                    if (val != '0 && fill > 0)
                    begin
                        found = 0;
                        hit = 0;
                        // first match counted from the head
                        for (i = 0; i < fill; i++)
                        begin
                            if (!found && store[(head + i) % fqd_pkg::QUEUE_DEPTH] == val)
                            begin
                                hit = i;
                                found = 1;
                            end
                        end
                        if (found)
                        begin
                            // later entries close up
                            for (i = hit; i + 1 < fill; i++)
                            begin
                                store[(head + i) % fqd_pkg::QUEUE_DEPTH] =
                                    store[(head + i + 1) % fqd_pkg::QUEUE_DEPTH];
                            end
                            fill--;
                            if (fill == 0)
                            begin
                                head = 0;
                            end
                            want.status = fqd_pkg::STATUS_OK;
                            n_delete_hits++;
                        end
                    end
                end
                default:
                begin
                    want.status = fqd_pkg::STATUS_OK;
                end
            endcase
            want.count = fqd_pkg::COUNT_OUT_W'(fill);
            expected_responses.push_back(want);
        endfunction

        // compare one accepted response with the oldest prediction
        function void check_response(logic st, logic [fqd_pkg::ITEM_W-1:0] v,
                                     logic [fqd_pkg::COUNT_OUT_W-1:0] c);
            queue_result_t want;
            n_responses++;
            if (expected_responses.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("[%0t] response with no request waiting:", $realtime);
                    $display("    status=%0d value=%h count=%0d", st, v, c);
                end
                return;
            end
            want = expected_responses.pop_front();
            if (st !== want.status || v !== want.value || c !== want.count)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("[%0t] mismatch: expected status=%0d value=%h count=%0d,",
                             $realtime, want.status, want.value, want.count);
                    $display("    got status=%0d value=%h count=%0d", st, v, c);
                end
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [fqd_pkg::OP_W-1:0]        operation = fqd_pkg::OP_LENGTH;
    logic [fqd_pkg::ITEM_W-1:0]      item_value = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            status;
    logic [fqd_pkg::ITEM_W-1:0]      value_out;
    logic [fqd_pkg::COUNT_OUT_W-1:0] entry_count;

    queue_scoreboard sb;

    fifo_queue_with_delete u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        sb = new();
    end

    // transfer monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.record_request(operation, item_value);
            end
            if (out_valid && out_ready)
            begin
                sb.check_response(status, value_out, entry_count);
            end
        end
    end

    // offer one request and hold it until the transfer
    task automatic send_item(input logic [fqd_pkg::OP_W-1:0] op,
                             input logic [fqd_pkg::ITEM_W-1:0] val);
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        item_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // sender gap, request valid dropped for a length set by n, n at least one
    task automatic pause_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // receiver: stall pattern of its own plus one long hold-off
    initial
    begin : receiver
        int mode;
        int len;
        int k;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sb.n_responses >= 400)
            begin
                held = 1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (299) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 60);
            for (k = 0; k < len; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 5) == 0);
                    default: out_ready <= k[0];
                endcase
            end
        end
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int                         sent;
        int                         burst;
        int                         bias;
        int                         j;
        int                         r;
        int                         waited;
        bit                         paused;
        logic [fqd_pkg::OP_W-1:0]   op;
        logic [fqd_pkg::ITEM_W-1:0] val;
        paused = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // empty queue corner cases
        send_item(fqd_pkg::OP_LENGTH, 32'h0);
        send_item(fqd_pkg::OP_DEQUEUE, 32'h0);
        send_item(fqd_pkg::OP_DELETE, 32'h0000_0005);
        send_item(fqd_pkg::OP_ENQUEUE, 32'h0);
        // single entry: null delete, then delete of the only entry
        send_item(fqd_pkg::OP_ENQUEUE, 32'h0000_0001);
        send_item(fqd_pkg::OP_DELETE, 32'h0);
        send_item(fqd_pkg::OP_DELETE, 32'h0000_0001);
        // fill to full, extremes of the value field included
        send_item(fqd_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
        send_item(fqd_pkg::OP_ENQUEUE, 32'h0000_0001);
        send_item(fqd_pkg::OP_ENQUEUE, 32'h8000_0000);
        for (j = 3; j < fqd_pkg::QUEUE_DEPTH; j++)
        begin
            send_item(fqd_pkg::OP_ENQUEUE, 32'h1000_0000 + j);
        end
        send_item(fqd_pkg::OP_ENQUEUE, 32'h5555_AAAA);
        // delete not found, middle, head, tail
        send_item(fqd_pkg::OP_DELETE, 32'h7FFF_FFFF);
        send_item(fqd_pkg::OP_DELETE, 32'h1000_0008);
        send_item(fqd_pkg::OP_DELETE, 32'hFFFF_FFFF);
        send_item(fqd_pkg::OP_DELETE, 32'h1000_000F);
        // duplicate value: delete takes the one nearer the head
        send_item(fqd_pkg::OP_ENQUEUE, 32'h1000_0005);
        send_item(fqd_pkg::OP_DELETE, 32'h1000_0005);
        // value field ignored on dequeue and length query
        send_item(fqd_pkg::OP_DEQUEUE, 32'hDEAD_BEEF);
        send_item(fqd_pkg::OP_LENGTH, 32'hFFFF_FFFF);

        // random bursts with a fill, drain or balanced bias
        sent = 0;
        while (sent < 1300)
        begin
            bias  = $urandom_range(0, 2);
            burst = $urandom_range(1, 24);
            for (j = 0; j < burst; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    val = '0;
                end
                else if (r < 80)
                begin
                    val = fqd_pkg::ITEM_W'($urandom_range(1, 12));
                end
                else
                begin
                    val = $urandom;
                end
                r = $urandom_range(0, 99);
                case (bias)
                    0: op = (r < 70) ? fqd_pkg::OP_ENQUEUE :
                            (r < 80) ? fqd_pkg::OP_DEQUEUE :
                            (r < 92) ? fqd_pkg::OP_DELETE : fqd_pkg::OP_LENGTH;
                    1: op = (r < 15) ? fqd_pkg::OP_ENQUEUE :
                            (r < 60) ? fqd_pkg::OP_DEQUEUE :
                            (r < 90) ? fqd_pkg::OP_DELETE : fqd_pkg::OP_LENGTH;
                    default: op = (r < 35) ? fqd_pkg::OP_ENQUEUE :
                                  (r < 65) ? fqd_pkg::OP_DEQUEUE :
                                  (r < 90) ? fqd_pkg::OP_DELETE : fqd_pkg::OP_LENGTH;
                endcase
                if (op == fqd_pkg::OP_DEQUEUE || op == fqd_pkg::OP_LENGTH)
                begin
                    val = $urandom;
                end
                send_item(op, val);
                sent++;
            end
            // drain completely once mid-run
            if (!paused && sent >= 700)
            begin
                paused = 1;
                pause_sender(1);
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 10));
            end
        end

        // drain and settle
        pause_sender(1);
        waited = 0;
        while (sb.pending() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("run covered %0d enqueue, %0d dequeue, %0d delete, %0d length requests",
                 sb.n_ops[fqd_pkg::OP_ENQUEUE], sb.n_ops[fqd_pkg::OP_DEQUEUE],
                 sb.n_ops[fqd_pkg::OP_DELETE], sb.n_ops[fqd_pkg::OP_LENGTH]);
        $display("queue went full %0d times, %0d full rejects, %0d deletes matched",
                 sb.n_full, sb.n_full_rejects, sb.n_delete_hits);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d failures, %0d responses missing", sb.failures, sb.pending());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
